/* hdl/isort_pkg.sv */
// Shared types and constants of the insertion sorter.
package isort_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_W = 32;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic                     ins;
    logic                     shift;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // What a cell shows to its neighbours.
  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] value;
  } cell_data_t;

endpackage

/* hdl/isort_if.sv */
// Handshake channels of the insertion sorter: input items and sorted results.
interface isort_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [isort_pkg::DATA_W-1:0] value;
  logic                               last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [isort_pkg::DATA_W-1:0] sorted_value;
  logic                               last_out;
  logic                               overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflow,
                output ready);
endinterface

/* hdl/isort_cell.sv */
// One cell of the sorting chain: holds a single value and its valid bit.
module isort_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  isort_pkg::cell_ctrl_t ctrl,
  input  isort_pkg::cell_data_t left_d,
  input  isort_pkg::cell_data_t right_d,
  output isort_pkg::cell_data_t cell_q
);

  logic                               valid_r;
  logic                               valid_nxt;
  logic signed [isort_pkg::DATA_W-1:0] value_r;
  logic signed [isort_pkg::DATA_W-1:0] value_nxt;
  logic                               gt;

  assign gt = valid_r && (value_r > ctrl.value);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      valid_nxt = right_d.valid;
      value_nxt = right_d.value;
    end else if (ctrl.ins) begin
      // A cell is rewritten when its value moves right or when it is the first free slot.
      if (gt || (!valid_r && left_d.valid)) begin
        valid_nxt = 1'b1;
        value_nxt = left_d.gt ? left_d.value : ctrl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign cell_q.valid = valid_r;
  assign cell_q.gt    = gt;
  assign cell_q.value = value_r;

endmodule

/* hdl/insertion_sorter_top.sv */
// Top level of the insertion sorter: cell chain, run control and output register.
//
// Usage: a run of signed 32-bit values enters on in_ch, one per transaction,
// the final one marked by last. Each value is inserted into a chain of DEPTH
// cells in the cycle it is accepted, so a run streams in at one value per
// cycle; equal values keep their arrival order. Values that arrive while all
// cells are occupied are discarded and every result of that run carries
// overflow.
// After the last transaction the chain drains through an output register on
// out_ch, smallest value first, one result per cycle while out_ch.ready is
// high; last_out marks the final result. Accepting the last input sets the drain state,
// which then loads the first result into the output register. While a run drains,
// in_ch.ready is low; it rises again once the final result is in the output register,
// so the next run may start while that result still waits.
// A stall on out_ch holds the output register and freezes the chain.
// Reset empties the chain and the output register; no clearing pass is needed.
module insertion_sorter_top (
  input logic               clk,
  input logic               rst_n,
  isort_in_if.sink          in_ch,
  isort_out_if.source       out_ch
);

  isort_pkg::cell_ctrl_t ctrl;
  isort_pkg::cell_data_t cell_q  [isort_pkg::DEPTH];
  isort_pkg::cell_data_t left_d  [isort_pkg::DEPTH];
  isort_pkg::cell_data_t right_d [isort_pkg::DEPTH];

  logic drain_r;
  logic drain_nxt;
  logic drop_r;
  logic drop_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic signed [isort_pkg::DATA_W-1:0] out_value_r;
  logic out_last_r;
  logic out_ovf_r;

  logic in_fire;
  logic full;
  logic load;
  logic final_elem;

  assign full       = cell_q[isort_pkg::DEPTH-1].valid;
  assign in_ch.ready = !drain_r;
  assign in_fire    = in_ch.valid && !drain_r;
  assign load       = drain_r && (!out_valid_r || out_ch.ready);
  assign final_elem = !right_d[0].valid;

  assign ctrl.ins   = in_fire && !full;
  assign ctrl.shift = load;
  assign ctrl.value = in_ch.value;

  for (genvar i = 0; i < isort_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      // The head has nothing to its left that could move in.
      assign left_d[i].valid = 1'b1;
      assign left_d[i].gt    = 1'b0;
      assign left_d[i].value = '0;
    end else begin : g_body
      assign left_d[i] = cell_q[i-1];
    end
    if (i == isort_pkg::DEPTH - 1) begin : g_tail
      assign right_d[i].valid = 1'b0;
      assign right_d[i].gt    = 1'b0;
      assign right_d[i].value = '0;
    end else begin : g_inner
      assign right_d[i] = cell_q[i+1];
    end

    isort_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .left_d  (left_d[i]),
      .right_d (right_d[i]),
      .cell_q  (cell_q[i])
    );
  end

  always_comb begin
    drain_nxt     = drain_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    if (in_fire && full) begin
      drop_nxt = 1'b1;
    end
    if (in_fire && in_ch.last) begin
      drain_nxt = 1'b1;
    end
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (final_elem) begin
        drain_nxt = 1'b0;
        drop_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drain_r     <= drain_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      out_value_r <= cell_q[0].value;
      out_last_r  <= final_elem;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.last_out     = out_last_r;
  assign out_ch.overflow     = out_ovf_r;

endmodule

/* test/tb.sv */
// Self-checking testbench of the insertion sorter: run stimulus, sorted-run prediction, checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [isort_pkg::DATA_W-1:0] value;
    logic                                last;
  } run_item_t;

  typedef struct {
    logic signed [isort_pkg::DATA_W-1:0] sorted_value;
    logic                                last_out;
    logic                                overflow;
  } sorted_result_t;

  localparam logic signed [isort_pkg::DATA_W-1:0] MOST_NEG =
    {1'b1, {(isort_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [isort_pkg::DATA_W-1:0] MOST_POS =
    {1'b0, {(isort_pkg::DATA_W-1){1'b1}}};
  localparam int RANDOM_ITEMS = 186;
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                feed_valid = 1'b0;
  logic signed [isort_pkg::DATA_W-1:0] feed_value = '0;
  logic                                feed_last = 1'b0;
  logic                                take_ready = 1'b0;

  isort_in_if  in_ch ();
  isort_out_if out_ch ();

  assign in_ch.valid  = feed_valid;
  assign in_ch.value  = feed_value;
  assign in_ch.last   = feed_last;
  assign out_ch.ready = take_ready;

  insertion_sorter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  run_item_t      pending_items[$];
  sorted_result_t expected_sorted[$];

  // Predicted contents of the sorting chain for the run in progress.
  logic signed [isort_pkg::DATA_W-1:0] run_store [isort_pkg::DEPTH];
  int unsigned                         run_fill = 0;
  logic                                run_dropped = 1'b0;

  int unsigned cyc = 0;
  int          fault_count = 0;

  always @(posedge clk) cyc <= cyc + 1;

  // Both sides idle at random, apart from one calm stretch where they never do.
  function automatic bit take_break();
    if (cyc >= 300 && cyc < 650) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 30;
  endfunction

  // Inserts one accepted value and, on the final one of a run, queues the sorted run.
  function automatic void absorb_value(logic signed [isort_pkg::DATA_W-1:0] v,
                                       logic is_last);
    int unsigned pos;
    sorted_result_t res;
    if (run_fill >= isort_pkg::DEPTH) begin
      run_dropped = 1'b1;
    end else begin
      pos = run_fill;
      while (pos > 0 && run_store[pos-1] > v) begin
        run_store[pos] = run_store[pos-1];
        pos--;
      end
      run_store[pos] = v;
      run_fill++;
    end
    if (is_last) begin
      for (int k = 0; k < run_fill; k++) begin
        res.sorted_value = run_store[k];
        res.last_out     = (k + 1 == run_fill);
        res.overflow     = run_dropped;
        expected_sorted.push_back(res);
      end
      run_fill    = 0;
      run_dropped = 1'b0;
    end
  endfunction

  function automatic logic signed [isort_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return $signed($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 5))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return MOST_NEG + 1;
          3: return MOST_POS - 1;
          4: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_run(int len);
    run_item_t item;
    for (int i = 0; i < len; i++) begin
      item.value = pick_value();
      item.last  = (i == len - 1);
      pending_items.push_back(item);
    end
  endfunction

  function automatic void queue_item(logic signed [isort_pkg::DATA_W-1:0] v, logic is_last);
    run_item_t item;
    item.value = v;
    item.last  = is_last;
    pending_items.push_back(item);
  endfunction

  // Driver: a new transaction is offered only once the previous one has been taken.
  always @(posedge clk) begin
    run_item_t item;
    if (!rst_n) begin
      feed_valid <= 1'b0;
    end else begin
      if (feed_valid && in_ch.ready) begin
        absorb_value(feed_value, feed_last);
      end
      if (!feed_valid || in_ch.ready) begin
        if (pending_items.size() > 0 && !take_break()) begin
          item = pending_items.pop_front();
          feed_valid <= 1'b1;
          feed_value <= item.value;
          feed_last  <= item.last;
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      take_ready <= 1'b0;
    end else begin
      take_ready <= !take_break();
    end
  end

  // Monitor: each accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    sorted_result_t want;
    if (rst_n && out_ch.valid && take_ready) begin
      if (expected_sorted.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected result: value %0d last %b overflow %b",
                   out_ch.sorted_value, out_ch.last_out, out_ch.overflow);
        end
      end else begin
        want = expected_sorted.pop_front();
        if (out_ch.sorted_value !== want.sorted_value || out_ch.last_out !== want.last_out ||
            out_ch.overflow !== want.overflow) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected value %0d last %b overflow %b, got %0d %b %b",
                     want.sorted_value, want.last_out, want.overflow,
                     out_ch.sorted_value, out_ch.last_out, out_ch.overflow);
          end
        end
      end
    end
  end

  initial begin
    int queued;
    int len;

    // A run of one value, then the extremes of the field with ties among them.
    queue_item(-1, 1'b1);
    queue_item(MOST_POS, 1'b0);
    queue_item(MOST_NEG, 1'b0);
    queue_item('0, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(MOST_NEG, 1'b1);
    // A run longer than the chain, so that the final value itself is discarded.
    for (int i = 0; i < isort_pkg::DEPTH + 2; i++) begin
      queue_item(((i * 13) % 9) - 4, i == isort_pkg::DEPTH + 1);
    end

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: len = isort_pkg::DEPTH;
        1: len = $urandom_range(isort_pkg::DEPTH + 1, isort_pkg::DEPTH + 5);
        default: len = $urandom_range(1, isort_pkg::DEPTH);
      endcase
      queue_run(len);
      queued += len;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || feed_valid) @(posedge clk);
    while (expected_sorted.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
